// ===== src/jca_pkg.sv =====
package jca_pkg;

  // Frame store geometry and sample format
  localparam int unsigned FRAME_PIXELS = 4096;
  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned FACTOR_BITS  = 17;
  localparam int unsigned FRAC_BITS    = 16;

  localparam int unsigned ADDR_W  = $clog2(FRAME_PIXELS);
  localparam int unsigned COUNT_W = $clog2(FRAME_PIXELS + 1);
  localparam int unsigned STORE_W = SAMPLE_BITS + 1;

  // Datapath widths; products and differences in units of 2^-FRAC_BITS
  localparam int unsigned MUL_W  = SAMPLE_BITS + FACTOR_BITS + 1;
  localparam int unsigned PROD_W = SAMPLE_BITS + FRAC_BITS + 1;
  localparam int unsigned DIFF_W = PROD_W + 1;
  localparam int unsigned DEN_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned SEG_W  = DEN_W + 4;
  localparam int unsigned T_W    = DEN_W + 1;
  localparam int unsigned D_W    = DEN_W + 1;
  localparam int unsigned QUOT_W = 8;
  localparam int unsigned DIV_W  = T_W + QUOT_W;
  localparam int unsigned STEP_W = $clog2(QUOT_W);

  localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = FACTOR_BITS'(1 << FRAC_BITS);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [7:0] CHAN_ZERO  = 8'h00;
  localparam logic [7:0] CHAN_FULL  = 8'hFF;
  localparam logic [7:0] GRAY_DEGEN = 8'hCC;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_RB    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RANGE,
    ST_SCALE,
    ST_SEGMENT,
    ST_DIV_LOAD,
    ST_DIV,
    ST_ROUND,
    ST_OUT
  } state_e;

  // Jet segments, by gray level: blue rising, green rising, red rising with
  // blue falling, green falling, red falling
  typedef enum logic [2:0] {
    SEG_BLUE_RISE,
    SEG_GREEN_RISE,
    SEG_RED_RISE,
    SEG_GREEN_FALL,
    SEG_RED_FALL
  } seg_e;

endpackage

// ===== src/jet_colormap_autorange.sv =====
// Load word: taken while idle, writes the frame store, next word taken the cycle after.
// Emit word: invalid pixel or flat range runs FETCH, RANGE, OUT; other pixels also run
//   SCALE, SEGMENT, DIV_LOAD, DIV, ROUND; red-rising does two 8-step divisions.
//   The block takes the next word in the cycle after the result is registered.
// The shared restoring divider gives one quotient bit per cycle.
// Reset (rst_ni low, async): empty frame, factors 1.0, no swap; store contents undefined.
module jet_colormap_autorange import jca_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          sample_invalid_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    red_o,
  output logic [7:0]                    green_o,
  output logic [7:0]                    blue_o,
  output logic                          last_pixel_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [FACTOR_BITS-1:0]        cfg_data_i
);

  // ------------------------------------------------------------------
  // State and registers
  // ------------------------------------------------------------------
  state_e state_q, state_d;

  logic [FACTOR_BITS-1:0]        min_factor_q, max_factor_q;
  logic                          swap_rb_q;
  logic signed [SAMPLE_BITS-1:0] frame_min_q, frame_min_d;
  logic signed [SAMPLE_BITS-1:0] frame_max_q, frame_max_d;
  logic [COUNT_W-1:0]            load_count_q, load_count_d;
  logic [ADDR_W-1:0]             rd_ptr_q, rd_ptr_d;
  logic                          last_q;
  logic                          second_q;
  logic [STEP_W-1:0]             step_q;

  // Payload of the pixel pipeline
  logic [STORE_W-1:0]        rdata_q;
  logic signed [PROD_W-1:0]  lo_q, hi_q, vc_q;
  logic [DEN_W-1:0]          den_q;
  logic                      degen_q, bad_q;
  logic [SEG_W-1:0]          n8_q, den3_q, den5_q, den7_q, den9_q;
  seg_e                      seg_q;
  logic [T_W-1:0]            ta_q, tb_q;
  logic [DIV_W-1:0]          rem_q, dsh_q;
  logic [QUOT_W-1:0]         quo_q;
  logic [7:0]                chan_a_q, chan_b_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] red_q, green_q, blue_q;
  logic       last_pixel_q;

  // Frame store: sample in the low bits, invalid mark on top
  logic [STORE_W-1:0] store_mem [FRAME_PIXELS];

  // ------------------------------------------------------------------
  // Handshake decode (output block of the FSM)
  // ------------------------------------------------------------------
  logic load_fire, emit_fire, emit_go, out_free, out_load;

  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_OUT:  out_load   = out_free;
      default: ;
    endcase
  end

  assign load_fire = in_valid_i && in_ready_o && !command_i;
  assign emit_fire = in_valid_i && in_ready_o && command_i;
  // an emit on an empty frame is consumed without a result
  assign emit_go   = emit_fire && (load_count_q != '0);
  assign out_free  = !out_valid_q || out_ready_i;

  // ------------------------------------------------------------------
  // Load path: frame_start restarts count and extremes before the write
  // ------------------------------------------------------------------
  logic [COUNT_W-1:0]            eff_count;
  logic                          store_ok;
  logic signed [SAMPLE_BITS-1:0] base_min, base_max;

  assign eff_count = frame_start_i ? '0 : load_count_q;
  assign store_ok  = eff_count < COUNT_W'(FRAME_PIXELS);
  assign base_min  = frame_start_i ? SAMPLE_MAX : frame_min_q;
  assign base_max  = frame_start_i ? SAMPLE_MIN : frame_max_q;

  // Emit address: replay from the top once the pointer runs off the frame
  logic [ADDR_W-1:0]  rd_idx;
  logic [COUNT_W-1:0] idx_inc;
  logic               idx_last;

  assign rd_idx   = (COUNT_W'(rd_ptr_q) >= load_count_q) ? '0 : rd_ptr_q;
  assign idx_inc  = COUNT_W'(rd_idx) + COUNT_W'(1);
  assign idx_last = (idx_inc == load_count_q);

  always_comb begin
    frame_min_d  = frame_min_q;
    frame_max_d  = frame_max_q;
    load_count_d = load_count_q;
    rd_ptr_d     = rd_ptr_q;
    if (load_fire) begin
      if (frame_start_i) begin
        rd_ptr_d = '0;
      end
      if (store_ok) begin
        load_count_d = eff_count + COUNT_W'(1);
        frame_min_d  = base_min;
        frame_max_d  = base_max;
        if (!sample_invalid_i) begin
          if (sample_i < base_min) frame_min_d = sample_i;
          if (sample_i > base_max) frame_max_d = sample_i;
        end
      end
    end else if (emit_go) begin
      rd_ptr_d = idx_last ? '0 : idx_inc[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_fire && store_ok) begin
      store_mem[eff_count[ADDR_W-1:0]] <= {sample_invalid_i, sample_i};
    end
    if (emit_go) begin
      rdata_q <= store_mem[rd_idx];
    end
  end

  // ------------------------------------------------------------------
  // Pixel datapath
  // ------------------------------------------------------------------
  // lo = frame_min*min_factor, hi = frame_max*max_factor (Q.16)
  logic signed [MUL_W-1:0]  lo_full, hi_full;
  assign lo_full = MUL_W'(frame_min_q) * MUL_W'($signed({1'b0, min_factor_q}));
  assign hi_full = MUL_W'(frame_max_q) * MUL_W'($signed({1'b0, max_factor_q}));

  // Range and clamp
  logic signed [PROD_W-1:0] v_full, v_cl;
  logic signed [DIFF_W-1:0] diff;
  logic                     degen_now;

  assign v_full    = PROD_W'($signed({rdata_q[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}}));
  assign diff      = DIFF_W'(hi_q) - DIFF_W'(lo_q);
  assign degen_now = diff[DIFF_W-1] || (diff == '0);

  always_comb begin
    v_cl = v_full;
    if (v_full > hi_q) v_cl = hi_q;
    if (v_full < lo_q) v_cl = lo_q;
  end

  // Gray scaled by den: n8 = 8*(v-lo), compared against odd multiples of den
  logic signed [DIFF_W-1:0] num;
  logic [SEG_W-1:0]         d1;

  assign num = DIFF_W'(vc_q) - DIFF_W'(lo_q);
  assign d1  = SEG_W'(den_q);

  seg_e             seg_now;
  logic [SEG_W-1:0] ta_now;

  always_comb begin
    if (n8_q <= d1) begin
      seg_now = SEG_BLUE_RISE;
      ta_now  = n8_q + d1;
    end else if (n8_q <= den3_q) begin
      seg_now = SEG_GREEN_RISE;
      ta_now  = n8_q - d1;
    end else if (n8_q <= den5_q) begin
      seg_now = SEG_RED_RISE;
      ta_now  = n8_q - den3_q;
    end else if (n8_q <= den7_q) begin
      seg_now = SEG_GREEN_FALL;
      ta_now  = den7_q - n8_q;
    end else begin
      seg_now = SEG_RED_FALL;
      ta_now  = den9_q - n8_q;
    end
  end

  // Channel = round(255*t / (2*den)), ties to even; t <= 2*den keeps q < 256
  logic [T_W-1:0]   t_sel;
  logic [DIV_W-1:0] t_ext;
  logic             div_ge;

  assign t_sel  = second_q ? tb_q : ta_q;
  assign t_ext  = DIV_W'(t_sel);
  assign div_ge = (rem_q >= dsh_q);

  logic [D_W:0]  twice_rem, two_den;
  logic          round_up;
  logic [8:0]    rnd_sum;
  logic [7:0]    rnd;

  assign twice_rem = {rem_q[D_W-1:0], 1'b0};
  assign two_den   = (D_W + 1)'({den_q, 1'b0});
  assign round_up  = (twice_rem > two_den) || ((twice_rem == two_den) && quo_q[0]);
  assign rnd_sum   = {1'b0, quo_q} + 9'(round_up);
  assign rnd       = rnd_sum[8] ? CHAN_FULL : rnd_sum[7:0];

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_FETCH: begin
        lo_q <= lo_full[PROD_W-1:0];
        hi_q <= hi_full[PROD_W-1:0];
      end
      ST_RANGE: begin
        den_q   <= diff[DEN_W-1:0];
        degen_q <= degen_now;
        bad_q   <= rdata_q[SAMPLE_BITS];
        vc_q    <= v_cl;
      end
      ST_SCALE: begin
        n8_q   <= SEG_W'({num[DEN_W-1:0], 3'b000});
        den3_q <= d1 + (d1 << 1);
        den5_q <= d1 + (d1 << 2);
        den7_q <= (d1 << 3) - d1;
        den9_q <= (d1 << 3) + d1;
      end
      ST_SEGMENT: begin
        seg_q <= seg_now;
        ta_q  <= ta_now[T_W-1:0];
        tb_q  <= T_W'(den5_q - n8_q);
      end
      ST_DIV_LOAD: begin
        rem_q <= (t_ext << QUOT_W) - t_ext;
        dsh_q <= DIV_W'({den_q, 1'b0}) << (QUOT_W - 1);
        quo_q <= '0;
      end
      ST_DIV: begin
        if (div_ge) rem_q <= rem_q - dsh_q;
        quo_q <= {quo_q[QUOT_W-2:0], div_ge};
        dsh_q <= dsh_q >> 1;
      end
      ST_ROUND: begin
        if (second_q) chan_b_q <= rnd;
        else          chan_a_q <= rnd;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // FSM: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (emit_go) state_d = ST_FETCH;
      ST_FETCH:    state_d = ST_RANGE;
      ST_RANGE: begin
        if (degen_now || rdata_q[SAMPLE_BITS]) state_d = ST_OUT;
        else                                   state_d = ST_SCALE;
      end
      ST_SCALE:    state_d = ST_SEGMENT;
      ST_SEGMENT:  state_d = ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV:      if (step_q == '0) state_d = ST_ROUND;
      ST_ROUND: begin
        if (!second_q && (seg_q == SEG_RED_RISE)) state_d = ST_DIV_LOAD;
        else                                      state_d = ST_OUT;
      end
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      frame_min_q  <= SAMPLE_MAX;
      frame_max_q  <= SAMPLE_MIN;
      load_count_q <= '0;
      rd_ptr_q     <= '0;
      last_q       <= 1'b0;
      second_q     <= 1'b0;
      step_q       <= '0;
    end else begin
      state_q      <= state_d;
      frame_min_q  <= frame_min_d;
      frame_max_q  <= frame_max_d;
      load_count_q <= load_count_d;
      rd_ptr_q     <= rd_ptr_d;
      if (emit_go) last_q <= idx_last;
      // second pass only for blue in the red-rising segment
      if (state_q == ST_SEGMENT) second_q <= 1'b0;
      else if (state_q == ST_ROUND) second_q <= 1'b1;
      if (state_q == ST_DIV_LOAD) step_q <= STEP_W'(QUOT_W - 1);
      else if (state_q == ST_DIV) step_q <= step_q - STEP_W'(1);
    end
  end

  // ------------------------------------------------------------------
  // Color assembly and output register
  // ------------------------------------------------------------------
  logic [7:0] r_c, g_c, b_c;

  always_comb begin
    r_c = CHAN_ZERO;
    g_c = CHAN_ZERO;
    b_c = CHAN_ZERO;
    if (degen_q) begin
      r_c = GRAY_DEGEN;
      g_c = GRAY_DEGEN;
      b_c = GRAY_DEGEN;
    end else if (!bad_q) begin
      case (seg_q)
        SEG_BLUE_RISE:  b_c = chan_a_q;
        SEG_GREEN_RISE: begin
          g_c = chan_a_q;
          b_c = CHAN_FULL;
        end
        SEG_RED_RISE: begin
          r_c = chan_a_q;
          g_c = CHAN_FULL;
          b_c = chan_b_q;
        end
        SEG_GREEN_FALL: begin
          r_c = CHAN_FULL;
          g_c = chan_a_q;
        end
        default:        r_c = chan_a_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q        <= swap_rb_q ? b_c : r_c;
      green_q      <= g_c;
      blue_q       <= swap_rb_q ? r_c : b_c;
      last_pixel_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign last_pixel_o = last_pixel_q;

  // ------------------------------------------------------------------
  // Configuration registers; factors above 1.0 saturate
  // ------------------------------------------------------------------
  logic [FACTOR_BITS-1:0] cfg_factor;

  assign cfg_ready_o = 1'b1;
  assign cfg_factor  = (cfg_data_i > FACTOR_ONE) ? FACTOR_ONE : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_factor_q <= FACTOR_ONE;
      max_factor_q <= FACTOR_ONE;
      swap_rb_q    <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MIN_FACTOR: min_factor_q <= cfg_factor;
        REG_MAX_FACTOR: max_factor_q <= cfg_factor;
        REG_SWAP_RB:    swap_rb_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/jca_checker.sv =====
module jca_checker import jca_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       command_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic       last_pixel_o
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) && $stable(green_o)
      && $stable(blue_o) && $stable(last_pixel_o))
    else $error("result word changed while stalled");

  // a load word never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !command_i |=> !$rose(out_valid_o))
    else $error("result after load word");

  // results come from the busy pipeline, never straight from idle
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a busy cycle");

  // red and green both at flat gray come with blue at flat gray, as for a flat range
  a_flat_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (red_o == GRAY_DEGEN) && (green_o == GRAY_DEGEN)
      |-> blue_o == GRAY_DEGEN)
    else $error("partial flat gray pixel");

endmodule

bind jet_colormap_autorange jca_checker u_jca_checker (.*);
